/* rtl/assert_macros.svh */
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* rtl/bced_pkg.sv */
`default_nettype none

package bced_pkg;

  localparam int unsigned MSEC_W     = 32;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CLICK_W    = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Operation codes of an input request.
  localparam logic OP_CHANGE = 1'b0;
  localparam logic OP_POLL   = 1'b1;

  // Pin levels (active low button).
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  // Register indexes, taken from paddr above the byte offset.
  localparam logic [0:0] REG_DEBOUNCE       = 1'b0;
  localparam logic [0:0] REG_CLICK_INTERVAL = 1'b1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET       = 16'd50;
  localparam logic [CFG_W-1:0] CLICK_INTERVAL_RESET = 16'd300;

  localparam logic [CLICK_W-1:0] CLICK_MAX = 8'hFF;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_PRESSED  = 2'd1,
    KIND_RELEASED = 2'd2,
    KIND_CLICKED  = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_msec;
    logic [CFG_W-1:0] run_gap_msec;
  } cfg_t;

  typedef struct packed {
    logic              operation;
    logic              pin_level;
    logic [MSEC_W-1:0] now_msec;
  } in_item_t;

  typedef struct packed {
    event_kind_t        event_kind;
    logic [MSEC_W-1:0]  event_msec;
    logic [CLICK_W-1:0] clicks;
  } out_item_t;

  typedef struct packed {
    logic              level;
    logic [MSEC_W-1:0] msec;
  } edge_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic  empty;
    logic  full;
    edge_t head;
  } q_stat_t;

endpackage

`default_nettype wire

/* rtl/bced_if.sv */
`default_nettype none

interface bced_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        pin_level;
  logic [31:0] now_msec;

  modport source (output valid, output operation, output pin_level, output now_msec,
                  input ready);
  modport sink   (input valid, input operation, input pin_level, input now_msec,
                  output ready);
endinterface

interface bced_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [31:0] event_msec;
  logic [7:0]  clicks;

  modport source (output valid, output event_kind, output event_msec, output clicks,
                  input ready);
  modport sink   (input valid, input event_kind, input event_msec, input clicks,
                  output ready);
endinterface

`default_nettype wire

/* rtl/bced_cfg.sv */
`default_nettype none

module bced_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bced_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [bced_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [bced_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output bced_pkg::cfg_t                      cfg
);
  import bced_pkg::*;

  logic [CFG_W-1:0] debounce_r, debounce_nxt;
  logic [CFG_W-1:0] interval_r, interval_nxt;
  logic [0:0]       reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    debounce_nxt = debounce_r;
    interval_nxt = interval_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DEBOUNCE:       debounce_nxt = pwdata[CFG_W-1:0];
        REG_CLICK_INTERVAL: interval_nxt = pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE:       prdata = {{(CFG_DATA_W-CFG_W){1'b0}}, debounce_r};
      REG_CLICK_INTERVAL: prdata = {{(CFG_DATA_W-CFG_W){1'b0}}, interval_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      interval_r <= CLICK_INTERVAL_RESET;
    end else begin
      debounce_r <= debounce_nxt;
      interval_r <= interval_nxt;
    end
  end

  assign cfg.debounce_msec = debounce_r;
  assign cfg.run_gap_msec  = interval_r;

endmodule

`default_nettype wire

/* rtl/bced_queue.sv */
`default_nettype none

module bced_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bced_pkg::q_ctrl_t ctrl,
  input  bced_pkg::edge_t   wr_entry,
  output bced_pkg::q_stat_t stat
);
  import bced_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  edge_t mem [DEPTH];

  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  edge_t            rd_data_r;
  edge_t            wr_data_r;
  logic             fwd_r;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    if (ctrl.push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
      fill_nxt   = fill_r + 1'b1;
    end else if (ctrl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      fill_nxt   = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Storage plus a registered read of the next head; forward a write that
  // lands on the slot being read in the same cycle.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
    rd_data_r <= mem[rd_ptr_nxt];
    wr_data_r <= wr_entry;
    fwd_r     <= ctrl.push && (wr_ptr_r == rd_ptr_nxt);
  end

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FULL_CNT);
  assign stat.head  = fwd_r ? wr_data_r : rd_data_r;

endmodule

`default_nettype wire

/* rtl/bced_eval.sv */
`default_nettype none

module bced_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  bced_pkg::cfg_t      cfg,
  input  bced_pkg::in_item_t  item,
  input  logic                fire,
  input  bced_pkg::q_stat_t   q_stat,
  output bced_pkg::q_ctrl_t   q_ctrl,
  output bced_pkg::edge_t     q_wr_entry,
  output bced_pkg::out_item_t result
);
  import bced_pkg::*;

  logic               level_now_r, level_now_nxt;
  logic [MSEC_W-1:0]  last_edge_r, last_edge_nxt;
  logic [MSEC_W-1:0]  press_start_r, press_start_nxt;
  logic [CLICK_W-1:0] click_total_r, click_total_nxt;

  logic [MSEC_W-1:0]  interval_ext;
  logic [MSEC_W-1:0]  since_edge;
  logic [MSEC_W-1:0]  head_age;
  logic [MSEC_W-1:0]  now_age;
  logic               edge_ok;
  logic               run_open;
  logic               head_late;
  logic               now_late;
  logic [CLICK_W-1:0] click_base;

  assign interval_ext = {{(MSEC_W-CFG_W){1'b0}}, cfg.run_gap_msec};
  assign since_edge   = item.now_msec - last_edge_r;
  assign head_age     = q_stat.head.msec - press_start_r;
  assign now_age      = item.now_msec - press_start_r;
  assign run_open     = (click_total_r != '0);
  assign head_late    = (head_age > interval_ext);
  assign now_late     = (now_age > interval_ext);
  assign edge_ok      = (item.pin_level != level_now_r) &&
                        (since_edge >= {{(MSEC_W-CFG_W){1'b0}}, cfg.debounce_msec});
  assign click_base   = head_late ? '0 : click_total_r;

  assign q_wr_entry.level = item.pin_level;
  assign q_wr_entry.msec  = item.now_msec;

  always_comb begin
    level_now_nxt   = level_now_r;
    last_edge_nxt   = last_edge_r;
    press_start_nxt = press_start_r;
    click_total_nxt = click_total_r;
    q_ctrl          = '0;
    result.event_kind = KIND_NONE;
    result.event_msec = item.now_msec;
    result.clicks     = '0;

    if (item.operation == OP_CHANGE) begin
      if (edge_ok) begin
        last_edge_nxt = item.now_msec;
        q_ctrl.push   = !q_stat.full;
      end
    end else if (!q_stat.empty) begin
      result.event_msec = q_stat.head.msec;
      if (run_open && head_late) begin
        // Close the run; keep the head queued.
        result.event_kind = KIND_CLICKED;
        result.clicks     = click_total_r;
        click_total_nxt   = '0;
        press_start_nxt   = '0;
      end else begin
        q_ctrl.pop = 1'b1;
        if (q_stat.head.level == LEVEL_PRESSED) begin
          result.event_kind = KIND_PRESSED;
          press_start_nxt   = q_stat.head.msec;
          click_total_nxt   = (click_base == CLICK_MAX) ? click_base : click_base + 1'b1;
        end else begin
          result.event_kind = KIND_RELEASED;
        end
      end
    end else if (run_open && now_late) begin
      result.event_kind = KIND_CLICKED;
      result.clicks     = click_total_r;
      click_total_nxt   = '0;
    end

    level_now_nxt = item.pin_level;

    if (!fire) begin
      level_now_nxt   = level_now_r;
      last_edge_nxt   = last_edge_r;
      press_start_nxt = press_start_r;
      click_total_nxt = click_total_r;
      q_ctrl          = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_now_r   <= LEVEL_RELEASED;
      last_edge_r   <= '0;
      press_start_r <= '0;
      click_total_r <= '0;
    end else begin
      level_now_r   <= level_now_nxt;
      last_edge_r   <= last_edge_nxt;
      press_start_r <= press_start_nxt;
      click_total_r <= click_total_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/button_click_event_detector.sv */
// Channel   Dir  Handshake       Payload
// in_ch     in   valid / ready   operation, pin_level, now_msec
// out_ch    out  valid / ready   event_kind, event_msec, clicks
// cfg (APB) in   psel / penable  paddr, pwdata, prdata, pready
//
// One request per cycle sustained while out_ch takes events; a request waits in the input
// register, and a poll's event shows on out_ch the cycle after it leaves there.
// The edge ring has a registered read port, so the head entry is always
// prefetched for the next poll.
// Reset (rst_n, synchronous) empties the ring and loads register defaults.
// A poll stalls in the input register only while an event waits on out_ch.
`default_nettype none
`include "assert_macros.svh"

module button_click_event_detector #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bced_in_if.sink                         in_ch,
  bced_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bced_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bced_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bced_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import bced_pkg::*;

  cfg_t      cfg;
  q_ctrl_t   q_ctrl;
  q_stat_t   q_stat;
  edge_t     q_wr_entry;
  out_item_t result;

  // Input register.
  logic     stg_valid_r, stg_valid_nxt;
  in_item_t stg_item_r;
  logic     stg_fire;
  logic     stg_poll;

  // Result register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  bced_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bced_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (q_ctrl),
    .wr_entry (q_wr_entry),
    .stat     (q_stat)
  );

  bced_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item       (stg_item_r),
    .fire       (stg_fire),
    .q_stat     (q_stat),
    .q_ctrl     (q_ctrl),
    .q_wr_entry (q_wr_entry),
    .result     (result)
  );

  // Advance a change request at once; hold a poll until the result slot frees.
  assign stg_poll = (stg_item_r.operation == OP_POLL);
  assign stg_fire = stg_valid_r && (!stg_poll || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !stg_valid_r || stg_fire;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      stg_valid_nxt = 1'b1;
    end else if (stg_fire) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stg_fire && stg_poll) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on accept, load the event on a poll.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_item_r.operation <= in_ch.operation;
      stg_item_r.pin_level <= in_ch.pin_level;
      stg_item_r.now_msec  <= in_ch.now_msec;
    end
    if (stg_fire && stg_poll) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_kind = out_item_r.event_kind;
  assign out_ch.event_msec = out_item_r.event_msec;
  assign out_ch.clicks     = out_item_r.clicks;

  // Never write a full ring, never pop an empty one.
  `ASSERT_IMPLY(a_push_not_full, q_ctrl.push, !q_stat.full, "edge pushed into full ring")
  `ASSERT_IMPLY(a_pop_not_empty, q_ctrl.pop, !q_stat.empty, "edge popped from empty ring")
  // Push comes from a change request, pop from a poll: never both.
  `ASSERT_ALWAYS(a_push_pop_excl, !(q_ctrl.push && q_ctrl.pop), "push and pop together")
  // A click count travels only with a CLICKED event, and is never zero there.
  `ASSERT_IMPLY(a_clicks_kind, out_valid_r,
                (out_item_r.event_kind == KIND_CLICKED) == (out_item_r.clicks != '0),
                "click count does not match event kind")

endmodule

`default_nettype wire

/* test/button_click_event_detector_tb.sv */
module button_click_event_detector_tb;
  import bced_pkg::*;

  localparam int unsigned RING_DEPTH      = 8;
  localparam int unsigned RESET_CYCLES    = 12;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned LIMIT_CYCLES    = 200000;
  localparam int unsigned SCRIPT_LEN      = 25;
  localparam int unsigned IDLE_PCT        = 23;

  // One row of the opening script; has_want marks rows whose event is typed in.
  typedef struct {
    logic        op;
    logic        pin;
    logic [31:0] now;
    bit          has_want;
    out_item_t   want;
  } script_row_t;

  localparam out_item_t ANY = '0;

  logic clk;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bced_in_if  in_ch ();
  bced_out_if out_ch ();

  button_click_event_detector #(
    .QUEUE_DEPTH(RING_DEPTH)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Free-running clock, period 12.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Button model: our own copy of the debounce state, the edge ring and the
  // click run, plus the two timing registers as last written.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   debounce_ms = DEBOUNCE_RESET;
  logic [CFG_W-1:0]   interval_ms = CLICK_INTERVAL_RESET;
  logic               pin_now = LEVEL_RELEASED;
  logic               pin_prev = LEVEL_RELEASED;
  logic [31:0]        last_accept_ms = '0;
  edge_t              edge_ring [RING_DEPTH];
  int unsigned        ring_rd = 0;
  int unsigned        ring_wr = 0;
  int unsigned        ring_fill = 0;
  logic [31:0]        run_start_ms = '0;
  logic [CLICK_W-1:0] run_clicks = '0;

  out_item_t   expected_events [$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned cycle_count = 0;

  // Side channel from the driver: typed-in event of the request on the bus.
  bit          row_has_want = 1'b0;
  out_item_t   row_want = '0;

  // Idle rates and hold-off requests, set by the stimulus sequence.
  int unsigned source_idle_pct = IDLE_PCT;
  int unsigned sink_idle_pct = IDLE_PCT;
  int unsigned hold_requests = 0;
  int unsigned hold_granted = 0;
  int unsigned hold_left = 0;

  logic [31:0] clock_ms = '0;

  // Advance the model by one request; return 1 when the request yields an event.
  function automatic bit predict_event(input logic op, input logic pin,
                                       input logic [31:0] now, output out_item_t ev);
    edge_t       head;
    logic [31:0] span;
    ev       = '0;
    pin_prev = pin_now;
    pin_now  = pin;

    if (op == OP_CHANGE) begin
      span = now - last_accept_ms;
      if (pin_now != pin_prev && span >= 32'(debounce_ms)) begin
        // The edge counts for debounce even when the ring has no room.
        last_accept_ms = now;
        if (ring_fill < RING_DEPTH) begin
          edge_ring[ring_wr] = '{level: pin, msec: now};
          ring_wr = (ring_wr + 1) % RING_DEPTH;
          ring_fill++;
        end
      end
      return 1'b0;
    end

    if (ring_fill != 0) begin
      head = edge_ring[ring_rd];
      span = head.msec - run_start_ms;
      // A finished run is reported first; the head stays queued.
      if (run_clicks != 0 && span > 32'(interval_ms)) begin
        ev           = '{KIND_CLICKED, head.msec, run_clicks};
        run_clicks   = '0;
        run_start_ms = '0;
        return 1'b1;
      end
      ring_rd = (ring_rd + 1) % RING_DEPTH;
      ring_fill--;
      if (head.level == LEVEL_PRESSED) begin
        if (span > 32'(interval_ms)) run_clicks = '0;
        run_start_ms = head.msec;
        if (run_clicks != CLICK_MAX) run_clicks++;
        ev = '{KIND_PRESSED, head.msec, 8'd0};
      end else begin
        ev = '{KIND_RELEASED, head.msec, 8'd0};
      end
      return 1'b1;
    end

    // Empty ring: close a stale run, else report a NONE event.
    span = now - run_start_ms;
    if (run_clicks != 0 && span > 32'(interval_ms)) begin
      ev         = '{KIND_CLICKED, now, run_clicks};
      run_clicks = '0;
      return 1'b1;
    end
    ev = '{KIND_NONE, now, 8'd0};
    return 1'b1;
  endfunction

  task automatic report_if_differs(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted request, check every accepted event
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    out_item_t want;
    out_item_t got;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (predict_event(in_ch.operation, in_ch.pin_level, in_ch.now_msec, want)) begin
        if (row_has_want) want = row_want;
        expected_events.push_back(want);
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{event_kind_t'(out_ch.event_kind), out_ch.event_msec, out_ch.clicks};
      if (expected_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected event, expected none actual kind %0d msec %0h clicks %0d",
                 $time, got.event_kind, got.event_msec, got.clicks);
      end else begin
        want = expected_events.pop_front();
        report_if_differs("event_kind", 32'(want.event_kind), 32'(got.event_kind));
        report_if_differs("event_msec", want.event_msec, got.event_msec);
        report_if_differs("clicks", 32'(want.clicks), 32'(got.clicks));
      end
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_granted != hold_requests) begin
      hold_granted = hold_requests;
      hold_left    = HOLD_OFF_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("button_click_event_detector_tb: done, errors");
      $finish;
    end
  end

  // Offer one request, idling at random first; return once it is accepted.
  task automatic send_request(input logic op, input logic pin, input logic [31:0] now,
                              input bit has_want = 1'b0, input out_item_t want = '0);
    @(negedge clk);
    while ($urandom_range(99) < source_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    row_has_want = has_want;
    row_want     = want;
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.pin_level <= pin;
    in_ch.now_msec  <= now;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  // Drop valid, wait for every expected event, then let trailing changes settle.
  task automatic drain_events();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write, then read back; the model takes the value once written.
  task automatic write_register(input logic [0:0] index, input logic [CFG_W-1:0] value);
    logic [CFG_DATA_W-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    report_if_differs("register readback", CFG_DATA_W'(value), readback);
    if (index == REG_DEBOUNCE) debounce_ms = value;
    else interval_ms = value;
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] interval);
    write_register(REG_DEBOUNCE, debounce);
    write_register(REG_CLICK_INTERVAL, interval);
  endtask

  // Time step between gestures: hug the debounce and click-interval borders,
  // with an occasional wild jump across the whole 32-bit range.
  function automatic logic [31:0] pick_gap();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return $urandom_range(debounce_ms);
      2:       return 32'(debounce_ms);
      3:       return 32'(debounce_ms) + $urandom_range(interval_ms);
      4:       return 32'(interval_ms);
      5:       return 32'(interval_ms) + 32'd1;
      6:       return $urandom_range(4 * interval_ms + 100);
      default: return $urandom();
    endcase
  endfunction

  // Random traffic until the running request count reaches target. Mostly
  // clean press/release gestures with polls; the rest is contact bounce,
  // poll bursts and fully random requests.
  task automatic play_gestures(input int unsigned target);
    int unsigned pick;
    while (requests_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        clock_ms += pick_gap();
        send_request(OP_CHANGE, LEVEL_PRESSED, clock_ms);
        repeat ($urandom_range(2)) begin
          clock_ms += $urandom_range(20);
          send_request(OP_POLL, LEVEL_PRESSED, clock_ms);
        end
        clock_ms += pick_gap();
        send_request(OP_CHANGE, LEVEL_RELEASED, clock_ms);
        repeat ($urandom_range(3)) begin
          clock_ms += $urandom_range(20);
          send_request(OP_POLL, LEVEL_RELEASED, clock_ms);
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(2, 6)) begin
          clock_ms += $urandom_range(debounce_ms);
          send_request(OP_CHANGE, 1'($urandom_range(1)), clock_ms);
        end
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 10)) begin
          clock_ms += pick_gap();
          send_request(OP_POLL, 1'($urandom_range(1)), clock_ms);
        end
      end else begin
        clock_ms = $urandom();
        send_request(1'($urandom_range(1)), 1'($urandom_range(1)), clock_ms);
      end
    end
  endtask

  // Opening script, run at reset timing (debounce 50, interval 300).
  script_row_t opening_script [SCRIPT_LEN] = '{
    // empty ring, no run: plain NONE at both time extremes
    '{OP_POLL,   LEVEL_RELEASED, 32'd0,          1'b1, '{KIND_NONE, 32'd0, 8'd0}},
    '{OP_POLL,   LEVEL_RELEASED, 32'hFFFF_FFFF,  1'b1, '{KIND_NONE, 32'hFFFF_FFFF, 8'd0}},
    // edge too soon after time zero: rejected
    '{OP_CHANGE, LEVEL_PRESSED,  32'd20,         1'b0, ANY},
    '{OP_POLL,   LEVEL_RELEASED, 32'd30,         1'b1, '{KIND_NONE, 32'd30, 8'd0}},
    '{OP_CHANGE, LEVEL_PRESSED,  32'd100,        1'b0, ANY},
    '{OP_POLL,   LEVEL_PRESSED,  32'd110,        1'b1, '{KIND_PRESSED, 32'd100, 8'd0}},
    // empty ring, run one past the interval: CLICKED at the poll time
    '{OP_POLL,   LEVEL_RELEASED, 32'd401,        1'b1, '{KIND_CLICKED, 32'd401, 8'd1}},
    // fill the ring; the edge that finds it full is dropped
    '{OP_CHANGE, LEVEL_PRESSED,  32'd1000,       1'b0, ANY},
    '{OP_CHANGE, LEVEL_RELEASED, 32'd1060,       1'b0, ANY},
    '{OP_CHANGE, LEVEL_PRESSED,  32'd1120,       1'b0, ANY},
    '{OP_CHANGE, LEVEL_RELEASED, 32'd1180,       1'b0, ANY},
    '{OP_CHANGE, LEVEL_PRESSED,  32'd1240,       1'b0, ANY},
    '{OP_CHANGE, LEVEL_RELEASED, 32'd1300,       1'b0, ANY},
    '{OP_CHANGE, LEVEL_PRESSED,  32'd1360,       1'b0, ANY},
    '{OP_CHANGE, LEVEL_RELEASED, 32'd2000,       1'b0, ANY},
    '{OP_CHANGE, LEVEL_PRESSED,  32'd2060,       1'b0, ANY},
    // drain: a stale press restarts the run, four clicks, then the late
    // release head closes the run before it is popped itself
    '{OP_POLL,   LEVEL_PRESSED,  32'd2100,       1'b0, ANY},
    '{OP_POLL,   LEVEL_PRESSED,  32'd2101,       1'b0, ANY},
    '{OP_POLL,   LEVEL_PRESSED,  32'd2102,       1'b0, ANY},
    '{OP_POLL,   LEVEL_PRESSED,  32'd2103,       1'b0, ANY},
    '{OP_POLL,   LEVEL_PRESSED,  32'd2104,       1'b0, ANY},
    '{OP_POLL,   LEVEL_PRESSED,  32'd2105,       1'b0, ANY},
    '{OP_POLL,   LEVEL_PRESSED,  32'd2106,       1'b0, ANY},
    '{OP_POLL,   LEVEL_PRESSED,  32'd2107,       1'b0, ANY},
    '{OP_POLL,   LEVEL_PRESSED,  32'd2108,       1'b0, ANY}
  };

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value from time zero; hold reset.
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_CHANGE;
    in_ch.pin_level = LEVEL_RELEASED;
    in_ch.now_msec  = '0;
    out_ch.ready    = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the opening script on reset timing.
    for (int i = 0; i < SCRIPT_LEN; i++)
      send_request(opening_script[i].op, opening_script[i].pin, opening_script[i].now,
                   opening_script[i].has_want, opening_script[i].want);
    drain_events();
    clock_ms = 32'd5000;

    // Lowest timing: every edge passes debounce, every nonzero gap ends a run.
    set_timing(16'd0, 16'd0);
    play_gestures(requests_sent + 250);
    drain_events();

    // Highest timing. Open with a long result hold-off while polls keep
    // coming, so the block backs up and stalls its request side.
    set_timing(16'hFFFF, 16'hFFFF);
    source_idle_pct = 0;
    hold_requests++;
    repeat (30) begin
      clock_ms += $urandom_range(5);
      send_request(OP_POLL, 1'($urandom_range(1)), clock_ms);
    end
    source_idle_pct = IDLE_PCT;
    play_gestures(requests_sent + 170);
    drain_events();

    // Typical timing, no idling on either side for the whole stretch.
    set_timing(16'($urandom_range(5, 80)), 16'($urandom_range(100, 600)));
    source_idle_pct = 0;
    sink_idle_pct   = 0;
    play_gestures(requests_sent + 220);
    drain_events();
    source_idle_pct = IDLE_PCT;
    sink_idle_pct   = IDLE_PCT;

    // Saturate the click count: one long run of quick presses, each popped
    // right away, then a poll far past the interval to close the run.
    set_timing(16'd0, 16'hFFFF);
    repeat (RING_DEPTH + 2) send_request(OP_POLL, LEVEL_RELEASED, clock_ms);
    repeat (265) begin
      clock_ms += $urandom_range(1, 40);
      send_request(OP_CHANGE, LEVEL_PRESSED, clock_ms);
      send_request(OP_POLL, LEVEL_RELEASED, clock_ms);
    end
    clock_ms += 32'd70000;
    send_request(OP_POLL, LEVEL_RELEASED, clock_ms);
    drain_events();

    // Run across the 32-bit time wrap.
    set_timing(16'($urandom_range(0, 200)), 16'($urandom_range(0, 1000)));
    clock_ms = 32'hFFFF_F000;
    play_gestures(requests_sent + 200);
    drain_events();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("button_click_event_detector_tb: done, clean");
    end else begin
      $display("button_click_event_detector_tb: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bced_pkg.sv
rtl/bced_if.sv
rtl/bced_cfg.sv
rtl/bced_queue.sv
rtl/bced_eval.sv
rtl/button_click_event_detector.sv
test/button_click_event_detector_tb.sv
